// File: rtl/light_cluster_binning_macros.svh
// Assertion macros for the light cluster binning block.
`ifndef LIGHT_CLUSTER_BINNING_MACROS_SVH
`define LIGHT_CLUSTER_BINNING_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LCB_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error("lcb check failed");
`define LCB_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error("lcb check failed");
`define LCB_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error("lcb check failed");
`else
`define LCB_ASSERT(label, cond)
`define LCB_ASSERT_IMP(label, pre, post)
`define LCB_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/lcb_pkg.sv
// Types and constants for the light cluster binning block.
package lcb_pkg;
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_CLEAR  = 2'd1;
	localparam logic [1:0] KIND_ASSIGN = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;
	localparam int COORD_W = 24;
	localparam int INTENSITY_SCALE = 25600;

	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] cluster;
		logic [4:0]  slot;
		logic [9:0]  light_index;
		logic [23:0] intensity;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [23:0] box_max_x;
		logic signed [23:0] box_max_y;
		logic signed [23:0] box_max_z;
	} lcb_in_t;

	typedef struct packed {
		logic [11:0] hit_count;
		logic [11:0] dropped_count;
		logic [5:0]  list_count;
		logic [7:0]  list_entry;
	} lcb_out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load;
		logic clr_step;
		logic clr_start;
		logic walk_start;
		logic walk_step;
		logic read_issue;
		logic finish;
	} lcb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic walk_last;
		logic pipe_empty;
	} lcb_sts_t;
endpackage

// File: rtl/lcb_if.sv
// Valid/ready channel carrying one word.
interface lcb_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lcb_ctrl.sv
// Controller state machine for the light cluster binning block.
`include "light_cluster_binning_macros.svh"
module lcb_ctrl import lcb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [1:0] in_kind,
	input  logic      out_busy,
	output lcb_cmd_t  cmd,
	input  lcb_sts_t  sts
);
	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;
	localparam logic [2:0] ST_CLEAR = 3'd6;

	logic [2:0] state_q, state_d;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					cmd.capture = 1'b1;
					unique case (in_kind)
						KIND_LOAD: begin
							cmd.load = 1'b1;
							state_d = ST_DONE;
						end
						KIND_CLEAR: begin
							cmd.clr_start = 1'b1;
							state_d = ST_CLEAR;
						end
						KIND_ASSIGN: begin
							cmd.walk_start = 1'b1;
							state_d = ST_WALK;
						end
						KIND_READ: begin
							cmd.read_issue = 1'b1;
							state_d = ST_READ;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) state_d = ST_DONE;
			end
			ST_READ: state_d = ST_DONE;
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

	`LCB_ASSERT_IMP(a_ready_idle, in_ready, state_q == ST_IDLE)
	`LCB_ASSERT_NEXT(a_acc_leaves, acc, state_q != ST_IDLE)
	`LCB_ASSERT_NEXT(a_done_once, state_q == ST_DONE && !out_busy, state_q == ST_IDLE)
endmodule

// File: rtl/lcb_datapath.sv
// Box, count and list memories with the sphere-box test pipeline.
`include "light_cluster_binning_macros.svh"
module lcb_datapath import lcb_pkg::*; #(
	parameter int CLUSTERS    = 2048,
	parameter int LIST_DEPTH  = 32,
	parameter int LIGHT_LIMIT = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  lcb_in_t  in_word,
	input  lcb_cmd_t cmd,
	output lcb_sts_t sts,
	output lcb_out_t result
);
	localparam int CW  = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
	localparam int SW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int NW  = $clog2(LIST_DEPTH + 1);
	localparam int AW  = CW + SW;

	logic [6*COORD_W-1:0] box_mem [CLUSTERS];
	logic [NW-1:0]        cnt_mem [CLUSTERS];
	logic [7:0]           ent_mem [CLUSTERS << SW];

	lcb_in_t in_q;
	logic    light_ok_q;
	logic [CW:0] idx_q;
	logic [CW:0] clr_q;

	// stage 1: box and count reads
	logic          v_s1;
	logic [CW-1:0] c_s1;
	logic [6*COORD_W-1:0] box_s1;
	logic [NW-1:0] cnt_s1;
	// stage 2: per-axis distance
	logic          v_s2;
	logic [CW-1:0] c_s2;
	logic [NW-1:0] cnt_s2;
	logic [COORD_W:0] dx_s2, dy_s2, dz_s2;
	// stage 3: squares
	logic          v_s3;
	logic [CW-1:0] c_s3;
	logic [NW-1:0] cnt_s3;
	logic [2*COORD_W+1:0] qx_s3, qy_s3, qz_s3;
	// stage 4: compare and append
	logic [2*COORD_W+3:0] dsq;
	logic [2*COORD_W+3:0] thr_q;
	logic                 hit;

	logic [11:0] hits_q, drops_q;
	logic        rcl_ok_q;
	logic [7:0]  rent_q;
	logic        rd_ok_q;
	logic [SW-1:0] rslot_q;

	logic clr_busy;
	assign clr_busy = clr_q != CLUSTERS[CW:0];

	function automatic logic [COORD_W:0] axis_d(logic signed [COORD_W-1:0] c,
		logic signed [COORD_W-1:0] lo, logic signed [COORD_W-1:0] hi);
		logic signed [COORD_W-1:0] p;
		logic signed [COORD_W:0]   d;
		p = (c < hi) ? c : hi;
		if (p < lo) p = lo;
		d = {p[COORD_W-1], p} - {c[COORD_W-1], c};
		return d[COORD_W] ? -d : d;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_word;
			light_ok_q <= {22'd0, in_word.light_index} < LIGHT_LIMIT;
			thr_q <= (2*COORD_W+4)'(in_word.intensity) * (2*COORD_W+4)'(INTENSITY_SCALE);
			rslot_q <= SW'(in_word.slot);
			rd_ok_q <= ({21'd0, in_word.cluster} < CLUSTERS) &&
				({27'd0, in_word.slot} < LIST_DEPTH);
		end
		if (cmd.load && {21'd0, in_word.cluster} < CLUSTERS) begin
			box_mem[CW'(in_word.cluster)] <= {in_word.pos_x, in_word.box_max_x,
				in_word.pos_y, in_word.box_max_y, in_word.pos_z, in_word.box_max_z};
		end
		box_s1 <= box_mem[idx_q[CW-1:0]];
		c_s1 <= idx_q[CW-1:0];
		dx_s2 <= axis_d(in_q.pos_x, box_s1[143:120], box_s1[119:96]);
		dy_s2 <= axis_d(in_q.pos_y, box_s1[95:72], box_s1[71:48]);
		dz_s2 <= axis_d(in_q.pos_z, box_s1[47:24], box_s1[23:0]);
		c_s2 <= c_s1;
		cnt_s2 <= cnt_s1;
		qx_s3 <= dx_s2 * dx_s2;
		qy_s3 <= dy_s2 * dy_s2;
		qz_s3 <= dz_s2 * dz_s2;
		c_s3 <= c_s2;
		cnt_s3 <= cnt_s2;
		if (v_s3 && hit && cnt_s3 < LIST_DEPTH)
			ent_mem[{c_s3, SW'(cnt_s3)}] <= in_q.light_index[7:0];
		rent_q <= ent_mem[{CW'(in_q.cluster), rslot_q}];
	end

	// count memory: one write port, one read port
	logic          cw_en;
	logic [CW-1:0] cw_a;
	logic [NW-1:0] cw_d;
	logic [CW-1:0] cr_a;
	always_comb begin
		cw_en = 1'b0;
		cw_a = c_s3;
		cw_d = cnt_s3 + NW'(1);
		if (clr_busy) begin
			cw_en = 1'b1;
			cw_a = clr_q[CW-1:0];
			cw_d = '0;
		end else if (v_s3 && hit && cnt_s3 < LIST_DEPTH) begin
			cw_en = 1'b1;
		end
		cr_a = cmd.walk_step ? idx_q[CW-1:0] : CW'(in_q.cluster);
	end
	always_ff @(posedge clk) begin
		if (cw_en) cnt_mem[cw_a] <= cw_d;
		cnt_s1 <= cnt_mem[cr_a];
	end

	assign dsq = {2'b0, qx_s3} + {2'b0, qy_s3} + {2'b0, qz_s3};
	assign hit = dsq <= thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			clr_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			hits_q <= '0;
			drops_q <= '0;
			rcl_ok_q <= 1'b0;
		end else begin
			if (cmd.clr_start) clr_q <= '0;
			else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.walk_start) idx_q <= '0;
			else if (cmd.walk_step) idx_q <= idx_q + 1'b1;
			v_s1 <= cmd.walk_step && light_ok_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.capture) begin
				hits_q <= '0;
				drops_q <= '0;
			end else if (v_s3 && hit) begin
				hits_q <= hits_q + 12'd1;
				if (cnt_s3 >= LIST_DEPTH) drops_q <= drops_q + 12'd1;
			end
			if (cmd.read_issue) rcl_ok_q <= ({21'd0, in_word.cluster} < CLUSTERS);
		end
	end

	// one box per cycle; the next entry may depend on the one three stages back
	// only through the count of the same cluster, and each cluster is visited once
	assign sts.walk_last  = idx_q == (CW+1)'(CLUSTERS - 1);
	assign sts.clr_last   = clr_q == (CW+1)'(CLUSTERS - 1);
	assign sts.pipe_empty = !v_s1 && !v_s2 && !v_s3;

	always_comb begin
		result = '0;
		unique case (in_q.kind)
			KIND_ASSIGN: begin
				result.hit_count = hits_q;
				result.dropped_count = drops_q;
			end
			KIND_READ: begin
				result.list_count = rcl_ok_q ? 6'(cnt_s1) : 6'd0;
				result.list_entry = (rd_ok_q && NW'(rslot_q) < cnt_s1) ? rent_q : 8'd0;
			end
			default: result = '0;
		endcase
	end

	`LCB_ASSERT(a_drop_le_hit, drops_q <= hits_q)
	`LCB_ASSERT_IMP(a_walk_no_clear, cmd.walk_step, !clr_busy)
	`LCB_ASSERT_IMP(a_cnt_bound, v_s3, cnt_s3 <= LIST_DEPTH)
endmodule

// File: rtl/light_cluster_binning.sv
// Top level of the light cluster binning block.
// Channels: in_ch (sink) takes one request word, out_ch (source) returns one
// result word per request, valid/ready on both.
// Kind 0 loads one cluster box. Kind 1 clears every list count, one count
// entry a cycle. Kind 2 walks the box memory one box per cycle through a
// three-stage test pipeline. Kind 3 reads a count and a list slot. The walk
// over every cluster box sets the light time.
// One request is processed at a time; the next is taken once the controller
// is idle, while the previous result may still wait in the output register.
// After reset a clearing pass zeroes the list counts, during which
// in_ch.ready stays low. Box and list entry memories are not cleared.
// When the receiver stalls, the result holds in the output register; one
// more request may be taken, and its result waits until the register frees.
module light_cluster_binning import lcb_pkg::*; #(
	parameter int CLUSTERS    = 2048,
	parameter int LIST_DEPTH  = 32,
	parameter int LIGHT_LIMIT = 256
) (
	input logic clk,
	input logic arst_n,
	lcb_if.sink   in_ch,
	lcb_if.source out_ch
);
	lcb_cmd_t cmd;
	lcb_sts_t sts;
	lcb_out_t res;
	logic     ready;

	lcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(ready),
		.in_kind(in_ch.data.kind), .out_busy(out_ch.valid && !out_ch.ready),
		.cmd(cmd), .sts(sts)
	);
	assign in_ch.ready = ready;

	lcb_datapath #(.CLUSTERS(CLUSTERS), .LIST_DEPTH(LIST_DEPTH),
		.LIGHT_LIMIT(LIGHT_LIMIT)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_ch.data), .cmd(cmd), .sts(sts),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (cmd.finish) out_ch.valid <= 1'b1;
		else if (out_ch.ready) out_ch.valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) out_ch.data <= res;
	end
endmodule
